[rtl/hosts_line_domain_hasher_top_assert.svh]
// ----------------------------------------------------------------------------
// hosts_line_domain_hasher_top_assert.svh
// Assertion macros used by the line hasher top level.
// ----------------------------------------------------------------------------
`ifndef HOSTS_LINE_DOMAIN_HASHER_TOP_ASSERT_SVH
`define HOSTS_LINE_DOMAIN_HASHER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HLD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hld same-cycle check failed");

// antecedent implies consequent in the next cycle
`define HLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hld next-cycle check failed");

`endif

[rtl/hld_pkg.sv]
// ----------------------------------------------------------------------------
// hld_pkg
// Types, constants and helpers for the hosts line domain hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hld_pkg;

    // line buffer geometry
    localparam int LINE_BYTES = 256;
    localparam int IDX_W      = $clog2(LINE_BYTES);
    localparam logic [IDX_W-1:0] LINE_MAX = IDX_W'(LINE_BYTES - 1);

    localparam int CNT_W  = 20;
    localparam int HASH_W = 32;

    localparam logic [CNT_W-1:0]  MAX_DOMAINS_RST = 20'd145000;
    localparam logic [HASH_W-1:0] FNV_BASIS       = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME       = 32'd16777619;

    // input word kinds (carried in s_tuser)
    typedef enum logic [1:0] {
        MODE_DATA    = 2'd0,
        MODE_FLUSH   = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    // characters of interest
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // start command to the hash core
    typedef struct packed {
        logic             go;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] end_idx;
    } hld_cmd_t;

    // line buffer write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } hld_wr_t;

    // core status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } hld_stat_t;

    // fold upper case ASCII to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UA && c <= CH_UZ) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

endpackage

[rtl/hld_hash_core.sv]
// ----------------------------------------------------------------------------
// hld_hash_core
// Line buffer memory plus an iterative FNV-1a unit: one shared 32x32
// multiply walks the token, each byte in a read state, then a mix state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hld_hash_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hld_pkg::hld_wr_t          wr,
    input  hld_pkg::hld_cmd_t         cmd,
    output hld_pkg::hld_stat_t        stat,
    output logic [hld_pkg::HASH_W-1:0] hash
);
    import hld_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RD   = 3'b010,
        C_MUL  = 3'b100
    } core_state_t;

    core_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  end_reg, end_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        mem [LINE_BYTES];
    logic [HASH_W-1:0] mix;
    logic [HASH_W-1:0] prod;
    logic [IDX_W-1:0]  ptr_inc;
    logic              last_byte;

    // line store: one write, one registered read at the walk pointer
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // shared mixer
    assign mix       = h_reg ^ {{(HASH_W-8){1'b0}}, fold_case(rd_data_reg)};
    assign prod      = mix * FNV_PRIME;
    assign ptr_inc   = ptr_reg + IDX_W'(1);
    assign last_byte = (ptr_inc == end_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        h_next     = h_reg;
        case (state_reg)
            C_IDLE: begin
                if (cmd.go) begin
                    ptr_next   = cmd.first_idx;
                    end_next   = cmd.end_idx;
                    h_next     = FNV_BASIS;
                    state_next = C_RD;
                end
            end
            C_RD: begin
                state_next = C_MUL;
            end
            C_MUL: begin
                h_next     = prod;
                ptr_next   = ptr_inc;
                state_next = last_byte ? C_IDLE : C_RD;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ptr_reg <= ptr_next;
        end_reg <= end_next;
        h_reg   <= h_next;
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_MUL) && last_byte;
    assign hash      = h_reg;

endmodule

[rtl/hosts_line_domain_hasher_top.sv]
// ----------------------------------------------------------------------------
// hosts_line_domain_hasher_top
// Buffers blocklist lines and emits the case-insensitive FNV-1a hash of the
// last token of each usable line, with a running count and a cap.
//
//  channel  direction  tdata                          tuser
//  s_       in         [7:0] data_byte                [1:0] mode
//  m_       out        [31:0] hash, [51:32] count     [0] from_flush
//  cfg_     in         [19:0] hash_cap                -
//
// Data, restart and dropped words are handled as they are accepted. A line
// end that yields a hash stalls input through the shared read/multiply loop
// in the hash core, plus any wait for the output register to drain.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished word may sit in the output register while input is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hosts_line_domain_hasher_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic [1:0]                 s_tuser,   // [1:0] mode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,   // [31:0] token_hash, [51:32] domain_count
    output logic                       m_tuser,   // [0] from_flush
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hld_pkg::CNT_W-1:0]  cfg_data   // hash_cap
);
    import hld_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  max_reg, cnt_reg, cnt_next;

    // per-line trackers, built as bytes arrive
    logic [IDX_W-1:0]  len_reg, len_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        last_reg, last_next;
    logic              zero_seen_reg, zero_seen_next;
    logic [IDX_W-1:0]  zpos_reg, zpos_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic              slash_seen_reg, slash_seen_next;
    logic [IDX_W-1:0]  slash_pos_reg, slash_pos_next;
    logic              flush_reg, flush_next;

    logic              m_tvalid_reg;
    logic [HASH_W-1:0] m_hash_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    logic              m_flush_reg;

    hld_wr_t           wr;
    hld_cmd_t          cmd;
    hld_stat_t         stat;
    logic [HASH_W-1:0] core_hash;

    logic              in_fire, out_load;
    logic [1:0]        mode;
    logic [7:0]        din;
    logic              line_end, store_byte;
    logic [IDX_W-1:0]  len_eff, eff;
    logic              usable;

    hld_hash_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .cmd     (cmd),
        .stat    (stat),
        .hash    (core_hash)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign mode      = s_tuser;
    assign din       = s_tdata;

    // word decode
    assign line_end = in_fire && ((mode == MODE_DATA && din == CH_LF) ||
                                  (mode == MODE_FLUSH && len_reg != '0));
    assign store_byte = in_fire && mode == MODE_DATA && din != CH_LF && len_reg != LINE_MAX;

    // line-end verdict from the trackers
    assign len_eff = (len_reg != '0 && last_reg == CH_CR) ? len_reg - IDX_W'(1) : len_reg;
    assign eff     = zero_seen_reg ? zpos_reg : len_eff;
    assign usable  = len_eff != '0 && first_reg != CH_HASH && first_reg != CH_BANG &&
                     start_reg < eff && !(slash_seen_reg && slash_pos_reg >= start_reg) &&
                     cnt_reg < max_reg;

    assign wr.en   = store_byte;
    assign wr.addr = len_reg;
    assign wr.data = din;

    assign cmd.go        = line_end && usable;
    assign cmd.first_idx = start_reg;
    assign cmd.end_idx   = eff;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // trackers, count and sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        zero_seen_next  = zero_seen_reg;
        zpos_next       = zpos_reg;
        start_next      = start_reg;
        slash_seen_next = slash_seen_reg;
        slash_pos_next  = slash_pos_reg;
        flush_next      = flush_reg;

        if (store_byte) begin
            len_next  = len_reg + IDX_W'(1);
            last_next = din;
            if (len_reg == '0) begin
                first_next = din;
            end
            if (!zero_seen_reg) begin
                if (din == CH_NUL) begin
                    zero_seen_next = 1'b1;
                    zpos_next      = len_reg;
                end
                if (din == CH_SP || din == CH_TAB) begin
                    start_next = len_reg + IDX_W'(1);
                end
                if (din == CH_SLASH) begin
                    slash_seen_next = 1'b1;
                    slash_pos_next  = len_reg;
                end
            end
        end

        if (line_end || (in_fire && mode == MODE_RESTART)) begin
            len_next        = '0;
            zero_seen_next  = 1'b0;
            start_next      = '0;
            slash_seen_next = 1'b0;
        end
        if (in_fire && mode == MODE_RESTART) begin
            cnt_next = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd.go) begin
                    flush_next = (mode == MODE_FLUSH);
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            max_reg        <= MAX_DOMAINS_RST;
            len_reg        <= '0;
            zero_seen_reg  <= 1'b0;
            start_reg      <= '0;
            slash_seen_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            zero_seen_reg  <= zero_seen_next;
            start_reg      <= start_next;
            slash_seen_reg <= slash_seen_next;
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
        end
        first_reg     <= first_next;
        last_reg      <= last_next;
        zpos_reg      <= zpos_next;
        slash_pos_reg <= slash_pos_next;
        flush_reg     <= flush_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_hash_reg  <= core_hash;
            m_cnt_reg   <= cnt_reg + CNT_W'(1);
            m_flush_reg <= flush_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_cnt_reg, m_hash_reg};
    assign m_tuser  = m_flush_reg;

    // checks
    `include "hosts_line_domain_hasher_top_assert.svh"
    `HLD_ASSERT_SAME(a_ready_core_idle, s_tready, !stat.busy)
    `HLD_ASSERT_SAME(a_out_from_load, $rose(m_tvalid_reg), $past(state_reg == ST_OUT))
    `HLD_ASSERT_NEXT(a_start_busy, cmd.go, stat.busy && state_reg == ST_RUN)
    `HLD_ASSERT_SAME(a_cap_respected, cmd.go, cnt_reg < max_reg)
    `HLD_ASSERT_NEXT(a_cnt_step, out_load, cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule
